### hw/rtl/snrmix_pkg.sv
// Shared types and constants of the SNR-scaled noise mixer.
package snrmix_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int GAIN_BITS   = 24;
    localparam int SCALE_BITS  = 24;
    localparam int SCALE_FRAC  = 16;
    localparam int ENERGY_BITS = 43;

    // scale search: D = noise energy * gain, Q = signal energy * 2^48 / D
    localparam int PROD_BITS = ENERGY_BITS + GAIN_BITS;
    localparam int REM_BITS  = PROD_BITS + 1;
    localparam int QUOT_BITS = 2 * SCALE_BITS;
    localparam int SREM_BITS = SCALE_BITS + 2;
    localparam int STEP_BITS = $clog2(QUOT_BITS);

    // mixing datapath
    localparam int SQ_BITS   = 2 * SAMPLE_BITS;
    localparam int MAG_BITS  = SAMPLE_BITS + SCALE_BITS;
    localparam int RMAG_BITS = MAG_BITS - SCALE_FRAC + 1;
    localparam int SUM_BITS  = RMAG_BITS + 2;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_FETCH = 1'b1;

    localparam logic [GAIN_BITS-1:0]   GAIN_RESET = GAIN_BITS'(65536);
    localparam logic [SCALE_BITS-1:0]  SCALE_MAX  = '1;
    localparam logic [ENERGY_BITS-1:0] ENERGY_MAX = '1;

    typedef struct packed {
        logic                          req_type;
        logic signed [SAMPLE_BITS-1:0] signal_sample;
        logic signed [SAMPLE_BITS-1:0] noise_sample;
        logic                          load_last;
    } snr_in_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] mixed_sample;
        logic                          clipped;
        logic                          out_last;
    } snr_out_t;

endpackage

### hw/rtl/snr_scaled_noise_mixer_unit.sv
// Top level of the SNR-scaled noise mixer: pair store, energy sums, scale unit, mixer.
//
// Load requests write one signal/noise pair into a single pair memory and add the
// squares of both samples to two saturating 43-bit energy sums; a load is taken every
// cycle while in_stall is low. The first fetch request after loading computes the
// noise scale sqrt(signal_energy * 2^48 / (noi_energy * snr_gain)), unsigned Q8.16,
// saturated to all ones (then every sample of the example reports clipped). That
// computation runs before the first sample is read: a setup step, a shift-add
// multiplier for noi_energy * snr_gain, a compare, a restoring divider and a
// digit-by-digit square root, then a check of the read pointer. With zero noise
// energy it goes from setup straight to the check, and when the scale saturates
// it runs setup, multiply, compare and check. Every fetch with a sample left
// runs the pair memory read, the multiply of |noise| by the scale, and the
// round/add/saturate that fills the output register. While the scale unit or
// the mixer is busy, in_stall is high; a finished result waits in the output
// register and does not block the next request. A fetch with nothing left gives
// no result. A load after a fetch opens a new example; loads beyond MAX_SAMPLES
// pairs are dropped. load_last is carried for the source's benefit only: the
// example ends with the last pair loaded before a fetch. snr_gain is written
// through cfg_wr_en/cfg_wr_data and is used at the next scale computation.
module snr_scaled_noise_mixer_unit
    import snrmix_pkg::*;
#(
    parameter int MAX_SAMPLES = 4096
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  snr_in_t              in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output snr_out_t             out_data,
    input  logic                 cfg_wr_en,
    input  logic [GAIN_BITS-1:0] cfg_wr_data
);

    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int ADDR_W = $clog2(MAX_SAMPLES);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SC_INIT,
        ST_SC_MUL,
        ST_SC_CMP,
        ST_SC_DIV,
        ST_SC_SQRT,
        ST_CHECK,
        ST_MIX_MUL,
        ST_MIX_SUM
    } state_t;

    localparam logic signed [SUM_BITS-1:0] SUM_MAX = SUM_BITS'((2 ** (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [SUM_BITS-1:0] SUM_MIN = SUM_BITS'(-(2 ** (SAMPLE_BITS - 1)));

    state_t                   state_reg;
    logic [GAIN_BITS-1:0]     gain_reg;
    logic [ENERGY_BITS-1:0]   sig_energy_reg;
    logic [ENERGY_BITS-1:0]   noi_energy_reg;
    logic [CNT_W-1:0]         sample_count_reg;
    logic [CNT_W-1:0]         read_pointer_reg;
    logic [SCALE_BITS-1:0]    mix_scale_reg;
    logic                     scale_ready_reg;
    logic                     scale_clip_reg;

    // squares of the last loaded pair, added in the following cycle
    logic [SQ_BITS-1:0]       sig_sq_reg;
    logic [SQ_BITS-1:0]       noi_sq_reg;
    logic                     sq_valid_reg;

    // scale unit
    logic [PROD_BITS-1:0]     prod_reg;
    logic [PROD_BITS-1:0]     mcand_reg;
    logic [GAIN_BITS-1:0]     mplier_reg;
    logic [REM_BITS-1:0]      rem_reg;
    logic [QUOT_BITS-1:0]     quot_reg;
    logic [QUOT_BITS-1:0]     rad_reg;
    logic [SREM_BITS-1:0]     srem_reg;
    logic [SCALE_BITS-1:0]    root_reg;
    logic [STEP_BITS-1:0]     step_reg;

    // mixer
    logic [2*SAMPLE_BITS-1:0] pair_mem [MAX_SAMPLES];
    logic [2*SAMPLE_BITS-1:0] rd_data_reg;
    logic [MAG_BITS-1:0]      mag_reg;
    logic signed [SAMPLE_BITS-1:0] sig_reg;
    logic                     neg_reg;
    logic                     last_reg;
    logic                     out_valid_reg;
    snr_out_t                 out_data_reg;

    logic                     in_acc;
    logic                     is_load;
    logic                     load_clear;
    logic                     load_store;
    logic [CNT_W-1:0]         cnt_eff;
    logic                     fetch_go;
    logic                     mem_re;
    logic                     out_free;

    logic signed [SQ_BITS-1:0] sig_sq;
    logic signed [SQ_BITS-1:0] noi_sq;
    logic [ENERGY_BITS:0]     sig_sum;
    logic [ENERGY_BITS:0]     noi_sum;
    logic [ENERGY_BITS-1:0]   sig_energy_next;
    logic [ENERGY_BITS-1:0]   noi_energy_next;

    logic [REM_BITS-1:0]      rem_sh;
    logic                     div_ge;
    logic [REM_BITS-1:0]      rem_next;
    logic [QUOT_BITS-1:0]     quot_next;
    logic [SREM_BITS:0]       srem_sh;
    logic [SREM_BITS:0]       trial;
    logic                     sqrt_ge;
    logic [SREM_BITS-1:0]     srem_next;
    logic [SCALE_BITS-1:0]    root_next;

    logic signed [SAMPLE_BITS-1:0] mem_sig;
    logic signed [SAMPLE_BITS-1:0] mem_noi;
    logic [SAMPLE_BITS-1:0]   noi_abs;
    logic [MAG_BITS:0]        mag_round;
    logic [RMAG_BITS-1:0]     rmag;
    logic signed [SUM_BITS-1:0] mix_sum;
    logic signed [SAMPLE_BITS-1:0] mix_sat;
    logic                     mix_clip;

    // ---------------------------------------------------------------- request decode
    assign in_stall   = (state_reg != ST_IDLE);
    assign in_acc     = in_valid && !in_stall;
    assign is_load    = (in_data.req_type == REQ_LOAD);
    // a load after a fetch starts a new example
    assign load_clear = in_acc && is_load && scale_ready_reg;
    assign cnt_eff    = load_clear ? '0 : sample_count_reg;
    assign load_store = in_acc && is_load && (cnt_eff < CNT_W'(MAX_SAMPLES));
    assign fetch_go   = (read_pointer_reg < sample_count_reg);
    assign mem_re     = (in_acc && !is_load && scale_ready_reg && fetch_go)
                     || (state_reg == ST_CHECK && fetch_go);
    assign out_free   = !out_valid_reg || !out_stall;

    // ---------------------------------------------------------------- energy sums
    assign sig_sq = in_data.signal_sample * in_data.signal_sample;
    assign noi_sq = in_data.noise_sample * in_data.noise_sample;
    assign sig_sum = {1'b0, sig_energy_reg} + (ENERGY_BITS + 1)'(sig_sq_reg);
    assign noi_sum = {1'b0, noi_energy_reg} + (ENERGY_BITS + 1)'(noi_sq_reg);
    assign sig_energy_next = sig_sum[ENERGY_BITS] ? ENERGY_MAX : sig_sum[ENERGY_BITS-1:0];
    assign noi_energy_next = noi_sum[ENERGY_BITS] ? ENERGY_MAX : noi_sum[ENERGY_BITS-1:0];

    // ---------------------------------------------------------------- divider step
    // remainder stays below the divisor, so the doubled value fits REM_BITS
    assign rem_sh    = {rem_reg[REM_BITS-2:0], 1'b0};
    assign div_ge    = (rem_sh >= {1'b0, prod_reg});
    assign rem_next  = div_ge ? (rem_sh - {1'b0, prod_reg}) : rem_sh;
    assign quot_next = {quot_reg[QUOT_BITS-2:0], div_ge};

    // ---------------------------------------------------------------- root step
    assign srem_sh   = {srem_reg[SREM_BITS-2:0], rad_reg[QUOT_BITS-1 -: 2]};
    assign trial     = {1'b0, root_reg, 2'b01};
    assign sqrt_ge   = (srem_sh >= trial);
    assign srem_next = sqrt_ge ? SREM_BITS'(srem_sh - trial) : SREM_BITS'(srem_sh);
    assign root_next = {root_reg[SCALE_BITS-2:0], sqrt_ge};

    // ---------------------------------------------------------------- mixer
    assign mem_sig   = rd_data_reg[SAMPLE_BITS-1:0];
    assign mem_noi   = rd_data_reg[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign noi_abs   = mem_noi[SAMPLE_BITS-1] ? (SAMPLE_BITS'(0) - SAMPLE_BITS'(mem_noi))
                                              : SAMPLE_BITS'(mem_noi);
    // round half away from zero on the magnitude
    assign mag_round = {1'b0, mag_reg} + (MAG_BITS + 1)'(2 ** (SCALE_FRAC - 1));
    assign rmag      = mag_round[MAG_BITS -: RMAG_BITS];
    assign mix_sum   = neg_reg ? (SUM_BITS'(sig_reg) - $signed({2'b00, rmag}))
                               : (SUM_BITS'(sig_reg) + $signed({2'b00, rmag}));

    always_comb
    begin
        mix_clip = 1'b1;
        if (mix_sum > SUM_MAX)
        begin
            mix_sat = SUM_MAX[SAMPLE_BITS-1:0];
        end
        else if (mix_sum < SUM_MIN)
        begin
            mix_sat = SUM_MIN[SAMPLE_BITS-1:0];
        end
        else
        begin
            mix_sat  = mix_sum[SAMPLE_BITS-1:0];
            mix_clip = 1'b0;
        end
    end

    // ---------------------------------------------------------------- pair memory
    always_ff @(posedge clk)
    begin
        if (load_store)
        begin
            pair_mem[cnt_eff[ADDR_W-1:0]] <= {in_data.noise_sample, in_data.signal_sample};
        end
        if (mem_re)
        begin
            rd_data_reg <= pair_mem[read_pointer_reg[ADDR_W-1:0]];
        end
    end

    // ---------------------------------------------------------------- control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            gain_reg         <= GAIN_RESET;
            sig_energy_reg   <= '0;
            noi_energy_reg   <= '0;
            sample_count_reg <= '0;
            read_pointer_reg <= '0;
            mix_scale_reg    <= '0;
            scale_ready_reg  <= 1'b0;
            scale_clip_reg   <= 1'b0;
            sig_sq_reg       <= '0;
            noi_sq_reg       <= '0;
            sq_valid_reg     <= 1'b0;
            prod_reg         <= '0;
            mcand_reg        <= '0;
            mplier_reg       <= '0;
            rem_reg          <= '0;
            quot_reg         <= '0;
            rad_reg          <= '0;
            srem_reg         <= '0;
            root_reg         <= '0;
            step_reg         <= '0;
            mag_reg          <= '0;
            sig_reg          <= '0;
            neg_reg          <= 1'b0;
            last_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_data_reg     <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                gain_reg <= cfg_wr_data;
            end

            sig_sq_reg   <= SQ_BITS'(sig_sq);
            noi_sq_reg   <= SQ_BITS'(noi_sq);
            sq_valid_reg <= load_store;
            // a pending add never meets a clear: a clear needs a fetch in between
            if (sq_valid_reg)
            begin
                sig_energy_reg <= sig_energy_next;
                noi_energy_reg <= noi_energy_next;
            end
            else if (load_clear)
            begin
                sig_energy_reg <= '0;
                noi_energy_reg <= '0;
            end

            // output register: filled by the mixer, emptied when taken
            if (state_reg == ST_MIX_SUM && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc && is_load)
                    begin
                        if (load_clear)
                        begin
                            read_pointer_reg <= '0;
                            scale_ready_reg  <= 1'b0;
                            scale_clip_reg   <= 1'b0;
                        end
                        sample_count_reg <= load_store ? (cnt_eff + 1'b1) : cnt_eff;
                    end
                    else if (in_acc)
                    begin
                        if (!scale_ready_reg)
                        begin
                            state_reg <= ST_SC_INIT;
                        end
                        else if (fetch_go)
                        begin
                            read_pointer_reg <= read_pointer_reg + 1'b1;
                            last_reg  <= ((read_pointer_reg + 1'b1) == sample_count_reg);
                            state_reg <= ST_MIX_MUL;
                        end
                    end
                end

                ST_SC_INIT:
                begin
                    if (noi_energy_reg == '0)
                    begin
                        mix_scale_reg   <= '0;
                        scale_clip_reg  <= 1'b0;
                        scale_ready_reg <= 1'b1;
                        state_reg       <= ST_CHECK;
                    end
                    else
                    begin
                        prod_reg   <= '0;
                        mcand_reg  <= PROD_BITS'(noi_energy_reg);
                        mplier_reg <= gain_reg;
                        step_reg   <= '0;
                        state_reg  <= ST_SC_MUL;
                    end
                end

                ST_SC_MUL:
                begin
                    if (mplier_reg[0])
                    begin
                        prod_reg <= prod_reg + mcand_reg;
                    end
                    mcand_reg  <= {mcand_reg[PROD_BITS-2:0], 1'b0};
                    mplier_reg <= {1'b0, mplier_reg[GAIN_BITS-1:1]};
                    step_reg   <= step_reg + 1'b1;
                    if (step_reg == STEP_BITS'(GAIN_BITS - 1))
                    begin
                        state_reg <= ST_SC_CMP;
                    end
                end

                ST_SC_CMP:
                begin
                    // quotient reaches 2^48 exactly when signal energy >= divisor
                    if (PROD_BITS'(sig_energy_reg) >= prod_reg)
                    begin
                        mix_scale_reg   <= SCALE_MAX;
                        scale_clip_reg  <= 1'b1;
                        scale_ready_reg <= 1'b1;
                        state_reg       <= ST_CHECK;
                    end
                    else
                    begin
                        rem_reg   <= REM_BITS'(sig_energy_reg);
                        quot_reg  <= '0;
                        step_reg  <= '0;
                        state_reg <= ST_SC_DIV;
                    end
                end

                ST_SC_DIV:
                begin
                    rem_reg  <= rem_next;
                    quot_reg <= quot_next;
                    if (step_reg == STEP_BITS'(QUOT_BITS - 1))
                    begin
                        rad_reg   <= quot_next;
                        srem_reg  <= '0;
                        root_reg  <= '0;
                        step_reg  <= '0;
                        state_reg <= ST_SC_SQRT;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end

                ST_SC_SQRT:
                begin
                    srem_reg <= srem_next;
                    root_reg <= root_next;
                    rad_reg  <= {rad_reg[QUOT_BITS-3:0], 2'b00};
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_BITS'(SCALE_BITS - 1))
                    begin
                        mix_scale_reg   <= root_next;
                        scale_clip_reg  <= 1'b0;
                        scale_ready_reg <= 1'b1;
                        state_reg       <= ST_CHECK;
                    end
                end

                ST_CHECK:
                begin
                    if (fetch_go)
                    begin
                        read_pointer_reg <= read_pointer_reg + 1'b1;
                        last_reg  <= ((read_pointer_reg + 1'b1) == sample_count_reg);
                        state_reg <= ST_MIX_MUL;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end

                ST_MIX_MUL:
                begin
                    mag_reg   <= MAG_BITS'(noi_abs * mix_scale_reg);
                    sig_reg   <= mem_sig;
                    neg_reg   <= mem_noi[SAMPLE_BITS-1];
                    state_reg <= ST_MIX_SUM;
                end

                ST_MIX_SUM:
                begin
                    if (out_free)
                    begin
                        out_data_reg.mixed_sample <= mix_sat;
                        out_data_reg.clipped      <= mix_clip || scale_clip_reg;
                        out_data_reg.out_last     <= last_reg;
                        state_reg                 <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ---------------------------------------------------------------- assertions
    a_ptr_le_count: assert property (@(posedge clk) disable iff (!rst_n)
        read_pointer_reg <= sample_count_reg)
        else $error("read pointer passed sample count");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sample_count_reg <= CNT_W'(MAX_SAMPLES))
        else $error("sample count beyond store depth");

    a_mix_needs_scale: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MIX_MUL || state_reg == ST_MIX_SUM) |-> scale_ready_reg)
        else $error("mixing without a computed scale");

    a_clip_scale_max: assert property (@(posedge clk) disable iff (!rst_n)
        scale_clip_reg |-> (mix_scale_reg == SCALE_MAX))
        else $error("scale flagged saturated but not at maximum");

endmodule
